>>> hdl/nmru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the NMRU replacement policy.
package nmru_pkg;

    localparam int WAYS  = 8;
    localparam int SETS  = 64;
    localparam int WAY_W = 3;
    localparam int SET_W = 6;
    localparam int PICK_MAX = (WAYS > 1) ? WAYS - 2 : 0;

    typedef enum logic [1:0] {
        KIND_TOUCH = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_INVAL = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        logic [WAYS-1:0]  vmask;
        logic [WAY_W-1:0] mru;
    } t_entry;

endpackage

>>> hdl/nmru_replacement_policy.sv
`timescale 1ns / 1ps
// A query's result is registered after the registered read of the state memory.
// Commands: busy holds for the read-modify-write cycle of the state memory and
//   blocks a new command, so no two accesses to one set overlap.
// Reset: synchronous, active low; every set reads as all ways invalid, MRU way 0.
// The result is shown for one cycle only; the receiver cannot stall it.
module nmru_replacement_policy (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  nmru_pkg::t_kind            i_kind,
    input  logic [nmru_pkg::SET_W-1:0] i_set_index,
    input  logic [nmru_pkg::WAY_W-1:0] i_way_index,
    input  logic [nmru_pkg::WAY_W-1:0] i_rand_pick,
    output logic                       o_valid,
    output logic [nmru_pkg::WAY_W-1:0] o_victim_way,
    output logic                       o_victim_was_invalid
);
    import nmru_pkg::*;

    logic             accept;
    logic             set_ok;
    logic             r_busy;
    t_kind            r_kind;
    logic [SET_W-1:0] r_set;
    logic [WAY_W-1:0] r_way;
    logic [WAY_W-1:0] r_pick;
    logic             r_valid;
    logic [WAY_W-1:0] r_victim_way;
    logic             r_victim_inv;

    t_entry           rd_entry;
    t_entry           upd_entry;
    logic             upd_wr_en;
    logic [WAY_W-1:0] vic_way;
    logic             vic_inv;

    assign accept = start && !r_busy;
    assign set_ok = (32'(r_set) < 32'(SETS));

    nmru_state_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_set   (i_set_index),
        .i_wr_en    (r_busy && set_ok && upd_wr_en),
        .i_wr_set   (r_set),
        .i_wr_entry (upd_entry),
        .o_rd_entry (rd_entry)
    );

    nmru_victim u_victim (
        .i_entry              (rd_entry),
        .i_kind               (r_kind),
        .i_way_index          (r_way),
        .i_rand_pick          (r_pick),
        .o_wr_en              (upd_wr_en),
        .o_entry              (upd_entry),
        .o_victim_way         (vic_way),
        .o_victim_was_invalid (vic_inv)
    );

    // capture the command; register the victim result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_set  <= i_set_index;
            r_way  <= i_way_index;
            r_pick <= i_rand_pick;
        end
        r_victim_way <= vic_way;
        r_victim_inv <= vic_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= accept;
            r_valid <= r_busy && set_ok && (r_kind == KIND_QUERY);
        end
    end

    assign busy                 = r_busy;
    assign o_valid              = r_valid;
    assign o_victim_way         = r_victim_way;
    assign o_victim_was_invalid = r_victim_inv;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) && !busy)
        else $error("result strobe without a command in flight");

    a_valid_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && r_kind != KIND_QUERY |=> !o_valid)
        else $error("result strobe for a command that is not a query");

endmodule

>>> hdl/nmru_state_mem.sv
`timescale 1ns / 1ps
// Per-set state memory with registered synchronous read and per-set valid flags.
module nmru_state_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [nmru_pkg::SET_W-1:0] i_rd_set,
    input  logic                       i_wr_en,
    input  logic [nmru_pkg::SET_W-1:0] i_wr_set,
    input  nmru_pkg::t_entry           i_wr_entry,
    output nmru_pkg::t_entry           o_rd_entry
);
    import nmru_pkg::*;

    t_entry          r_mem [SETS];
    logic [SETS-1:0] r_set_vld;
    t_entry          r_rd_data;
    logic            r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_set];
        end
    end

    // an entry not written since reset reads as all zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_set_vld[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_set_vld[i_rd_set];
            end
        end
    end

    assign o_rd_entry = r_rd_hit ? r_rd_data : t_entry'('0);

endmodule

>>> hdl/nmru_victim.sv
`timescale 1ns / 1ps
// Victim selection and state update for one set.
module nmru_victim (
    input  nmru_pkg::t_entry           i_entry,
    input  nmru_pkg::t_kind            i_kind,
    input  logic [nmru_pkg::WAY_W-1:0] i_way_index,
    input  logic [nmru_pkg::WAY_W-1:0] i_rand_pick,
    output logic                       o_wr_en,
    output nmru_pkg::t_entry           o_entry,
    output logic [nmru_pkg::WAY_W-1:0] o_victim_way,
    output logic                       o_victim_was_invalid
);
    import nmru_pkg::*;

    logic             way_ok;
    logic [WAYS-1:0]  way_bit;
    logic             found;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] pick;

    assign way_ok  = (32'(i_way_index) < 32'(WAYS));
    assign way_bit = WAYS'(1) << i_way_index;

    always_comb begin
        o_entry = i_entry;
        o_wr_en = 1'b0;
        case (i_kind)
            KIND_TOUCH, KIND_FILL: begin
                o_wr_en       = way_ok;
                o_entry.vmask = i_entry.vmask | way_bit;
                o_entry.mru   = i_way_index;
            end
            KIND_INVAL: begin
                o_wr_en       = way_ok;
                o_entry.vmask = i_entry.vmask & ~way_bit;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    // lowest invalid way wins
    always_comb begin
        found   = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_entry.vmask[w]) begin
                found   = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    // saturate the rank, then skip over the MRU way
    assign pick = (32'(i_rand_pick) > 32'(PICK_MAX)) ? WAY_W'(PICK_MAX) : i_rand_pick;

    always_comb begin
        if (WAYS == 1) begin
            o_victim_way         = '0;
            o_victim_was_invalid = ~i_entry.vmask[0];
        end else if (found) begin
            o_victim_way         = inv_way;
            o_victim_was_invalid = 1'b1;
        end else begin
            o_victim_way         = (pick >= i_entry.mru) ? pick + WAY_W'(1) : pick;
            o_victim_was_invalid = 1'b0;
        end
    end

endmodule

>>> tb/nmru_replacement_policy_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the NMRU replacement policy: directed and random commands.
module nmru_replacement_policy_test;
    import nmru_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1850;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic             was_invalid;
    } t_victim;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_kind              i_kind;
    logic [SET_W-1:0]   i_set_index;
    logic [WAY_W-1:0]   i_way_index;
    logic [WAY_W-1:0]   i_rand_pick;
    logic               o_valid;
    logic [WAY_W-1:0]   o_victim_way;
    logic               o_victim_was_invalid;

    // Shadow replacement state per set.
    logic [WAYS-1:0]    shadow_vmask [SETS];
    logic [WAY_W-1:0]   shadow_mru   [SETS];

    t_victim            victim_q [$];
    int unsigned        mismatch_count;
    int unsigned        cycle_count;

    nmru_replacement_policy dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_set_index          (i_set_index),
        .i_way_index          (i_way_index),
        .i_rand_pick          (i_rand_pick),
        .o_valid              (o_valid),
        .o_victim_way         (o_victim_way),
        .o_victim_was_invalid (o_victim_was_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Apply one accepted command to the shadow state; queue the victim for a query.
    function automatic void update_policy_shadow(input t_kind kind,
                                                 input logic [SET_W-1:0] set_idx,
                                                 input logic [WAY_W-1:0] way_idx,
                                                 input logic [WAY_W-1:0] pick);
        t_victim          victim;
        logic [WAYS-1:0]  vmask;
        int               rank;
        bit               found;
        if (set_idx >= SETS) begin
            return;
        end
        if (kind != KIND_QUERY) begin
            if (way_idx >= WAYS) begin
                return;
            end
            if (kind == KIND_INVAL) begin
                shadow_vmask[set_idx][way_idx] = 1'b0;
            end else begin
                shadow_vmask[set_idx][way_idx] = 1'b1;
                shadow_mru[set_idx] = way_idx;
            end
            return;
        end
        vmask = shadow_vmask[set_idx];
        found = 1'b0;
        victim = '0;
        if (WAYS == 1) begin
            victim.way = '0;
            victim.was_invalid = ~vmask[0];
            found = 1'b1;
        end
        for (int w = 0; w < WAYS && !found; w++) begin
            if (!vmask[w]) begin
                victim.way = WAY_W'(w);
                victim.was_invalid = 1'b1;
                found = 1'b1;
            end
        end
        if (!found) begin
            // Rank among the non-MRU ways, skipping over the MRU way.
            rank = (pick > PICK_MAX) ? PICK_MAX : int'(pick);
            if (rank >= int'(shadow_mru[set_idx])) begin
                rank = rank + 1;
            end
            victim.way = WAY_W'(rank);
            victim.was_invalid = 1'b0;
        end
        victim_q.push_back(victim);
    endfunction

    // Hold the command until busy is low at a clock edge; start stays high on return.
    task automatic send_cmd(input t_kind kind, input logic [SET_W-1:0] set_idx,
                            input logic [WAY_W-1:0] way_idx,
                            input logic [WAY_W-1:0] pick);
        start       <= 1'b1;
        i_kind      <= kind;
        i_set_index <= set_idx;
        i_way_index <= way_idx;
        i_rand_pick <= pick;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        update_policy_shadow(kind, set_idx, way_idx, pick);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (victim_q.size() == 0) begin
                $error("victim result with none expected: way %0d invalid %0b",
                       o_victim_way, o_victim_was_invalid);
                mismatch_count++;
            end else begin
                t_victim exp_victim;
                exp_victim = victim_q.pop_front();
                if (o_victim_way !== exp_victim.way) begin
                    $error("victim_way expected %0d actual %0d",
                           exp_victim.way, o_victim_way);
                    mismatch_count++;
                end
                if (o_victim_was_invalid !== exp_victim.was_invalid) begin
                    $error("victim_was_invalid expected %0b actual %0b",
                           exp_victim.was_invalid, o_victim_was_invalid);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_cmd(KIND_QUERY, '0, '0, '0);
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '1, '1);
    endtask

    task automatic test_full_set_victims();
        for (int w = 0; w < WAYS; w++) begin
            send_cmd(KIND_FILL, SET_W'(SETS - 1), WAY_W'(w), '0);
        end
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '0, '0);
        // Rank above the top saturates.
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '0, '1);
        send_cmd(KIND_TOUCH, SET_W'(SETS - 1), '0, '0);
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '1, '0);
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '0, WAY_W'(PICK_MAX));
    endtask

    task automatic test_invalidate_and_touch();
        send_cmd(KIND_INVAL, SET_W'(SETS - 1), '1, '0);
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '0, '1);
        // A touch alone validates the way.
        send_cmd(KIND_TOUCH, SET_W'(SETS - 1), '1, '0);
        send_cmd(KIND_QUERY, SET_W'(SETS - 1), '0, 3'd3);
        send_cmd(KIND_TOUCH, '0, 3'd5, '0);
        send_cmd(KIND_QUERY, '0, '0, '0);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      burst_len;
        int unsigned      gap_len;
        int unsigned      roll;
        t_kind            kind;
        logic [SET_W-1:0] set_idx;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst_len = $urandom_range(1, 24);
            for (int b = 0; b < burst_len && sent < RAND_ITEMS; b++) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) begin
                    kind = KIND_FILL;
                end else if (roll < 45) begin
                    kind = KIND_TOUCH;
                end else if (roll < 60) begin
                    kind = KIND_INVAL;
                end else begin
                    kind = KIND_QUERY;
                end
                // Keep most traffic on a few sets so they fill up completely.
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    set_idx = SET_W'($urandom_range(0, 1));
                end else if (roll < 85) begin
                    set_idx = SET_W'($urandom_range(SETS - 2, SETS - 1));
                end else begin
                    set_idx = SET_W'($urandom_range(0, SETS - 1));
                end
                send_cmd(kind, set_idx, WAY_W'($urandom_range(0, 7)),
                         WAY_W'($urandom_range(0, 7)));
                sent++;
            end
            // Leave some bursts back to back with no gap.
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap_len != 0) begin
                start <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        start          = 1'b0;
        i_kind         = KIND_TOUCH;
        i_set_index    = '0;
        i_way_index    = '0;
        i_rand_pick    = '0;
        i_rst_n        = 1'b0;
        for (int s = 0; s < SETS; s++) begin
            shadow_vmask[s] = '0;
            shadow_mru[s]   = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_full_set_victims();
        test_invalidate_and_touch();
        test_random_traffic();

        while (victim_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/nmru_pkg.sv
hdl/nmru_state_mem.sv
hdl/nmru_victim.sv
hdl/nmru_replacement_policy.sv
tb/nmru_replacement_policy_test.sv
